FILE: rtl/core/seven_segment_char_shift_driver_macros.svh
// ----------------------------------------------------------------------------
// seven segment char shift driver assertion macros
// shared concurrent assertion forms used by the driver
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_CHAR_SHIFT_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_CHAR_SHIFT_DRIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SSCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sscd same-cycle check failed");

// next-cycle implication, checked out of reset
`define SSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sscd next-cycle check failed");

`endif

FILE: rtl/core/sscd_pkg.sv
// ----------------------------------------------------------------------------
// sscd_pkg
// shared widths, character codes, glyph table and control types
// ----------------------------------------------------------------------------
`default_nettype none

package sscd_pkg;

    localparam int unsigned FrameBits = 16;
    localparam int unsigned PosW      = 4;
    localparam int unsigned CodeW     = 8;
    localparam int unsigned SelW      = 4;
    localparam int unsigned PatW      = 8;
    localparam int unsigned GlyphW    = 6;
    localparam int unsigned InDataW   = 16;
    localparam int unsigned OutDataW  = 8;

    localparam logic [CodeW-1:0] CharLowA  = 8'd97;
    localparam logic [CodeW-1:0] CharLowZ  = 8'd122;
    localparam logic [CodeW-1:0] CharZero  = 8'd48;
    localparam logic [CodeW-1:0] CharNine  = 8'd57;
    localparam logic [CodeW-1:0] LetterOfs = 8'd87;

    localparam logic [PatW-1:0] DotMask   = 8'h01;
    localparam logic [PatW-1:0] BlankPat  = 8'h00;
    localparam logic [PosW-1:0] LastPos   = 4'd15;

    // load and shift strobes shared by every cell of the chain
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    // segment pattern per glyph: bit 7 is segment a, bit 0 the dot
    function automatic logic [PatW-1:0] glyph_pattern(input logic [GlyphW-1:0] idx);
        logic [PatW-1:0] pat;
        unique case (idx)
            6'd0:  pat = 8'hFC;
            6'd1:  pat = 8'h60;
            6'd2:  pat = 8'hDA;
            6'd3:  pat = 8'hF2;
            6'd4:  pat = 8'h66;
            6'd5:  pat = 8'hB6;
            6'd6:  pat = 8'hBE;
            6'd7:  pat = 8'hE0;
            6'd8:  pat = 8'hFE;
            6'd9:  pat = 8'hE6;
            6'd10: pat = 8'hEE;
            6'd11: pat = 8'h3E;
            6'd12: pat = 8'h9C;
            6'd13: pat = 8'h7A;
            6'd14: pat = 8'h9E;
            6'd15: pat = 8'h8E;
            6'd16: pat = 8'hBC;
            6'd17: pat = 8'h2E;
            6'd18: pat = 8'h60;
            6'd19: pat = 8'h70;
            6'd20: pat = 8'hAE;
            6'd21: pat = 8'h1C;
            6'd22: pat = 8'hEC;
            6'd23: pat = 8'h2A;
            6'd24: pat = 8'h3A;
            6'd25: pat = 8'hCE;
            6'd26: pat = 8'hE6;
            6'd27: pat = 8'h0A;
            6'd28: pat = 8'hB6;
            6'd29: pat = 8'h1E;
            6'd30: pat = 8'h7C;
            6'd31: pat = 8'h38;
            6'd32: pat = 8'h38;
            6'd33: pat = 8'h6E;
            6'd34: pat = 8'h66;
            6'd35: pat = 8'hDA;
            default: pat = BlankPat;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sscd_encode.sv
// ----------------------------------------------------------------------------
// sscd_encode
// character to segment pattern, board wiring and inversion into a 16-bit frame
// ----------------------------------------------------------------------------
`default_nettype none

module sscd_encode (
    input  wire logic [sscd_pkg::SelW-1:0]      i_digit_select,
    input  wire logic [sscd_pkg::CodeW-1:0]     i_char_code,
    input  wire logic                           i_dot_on,
    input  wire logic                           i_display_on,
    output logic      [sscd_pkg::FrameBits-1:0] o_frame
);

    logic [sscd_pkg::PatW-1:0]   w_glyph;
    logic [sscd_pkg::PatW-1:0]   w_pat;
    logic [sscd_pkg::CodeW-1:0]  w_ofs;
    logic [7:0]                  w_first;
    logic [7:0]                  w_second;

    always_comb begin
        w_ofs   = '0;
        w_glyph = sscd_pkg::BlankPat;
        if (i_char_code >= sscd_pkg::CharLowA && i_char_code <= sscd_pkg::CharLowZ) begin
            w_ofs   = i_char_code - sscd_pkg::LetterOfs;
            w_glyph = sscd_pkg::glyph_pattern(w_ofs[sscd_pkg::GlyphW-1:0]);
        end else if (i_char_code >= sscd_pkg::CharZero
                     && i_char_code <= sscd_pkg::CharNine) begin
            w_ofs   = i_char_code - sscd_pkg::CharZero;
            w_glyph = sscd_pkg::glyph_pattern(w_ofs[sscd_pkg::GlyphW-1:0]);
        end

        // a disabled digit drops the dot as well
        if (!i_display_on) begin
            w_pat = sscd_pkg::BlankPat;
        end else if (i_dot_on) begin
            w_pat = w_glyph | sscd_pkg::DotMask;
        end else begin
            w_pat = w_glyph;
        end

        w_first  = {1'b0, w_pat[7], w_pat[4], w_pat[5], w_pat[0], i_digit_select[3], 2'b00};
        w_second = {1'b0, w_pat[1], w_pat[6], w_pat[3], w_pat[2], i_digit_select[1],
                    i_digit_select[0], i_digit_select[2]};
        o_frame  = ~{w_second, w_first};
    end

endmodule

`default_nettype wire

FILE: rtl/core/sscd_cell.sv
// ----------------------------------------------------------------------------
// sscd_cell
// one stage of the serial chain: loads a frame bit or takes its neighbor's
// ----------------------------------------------------------------------------
`default_nettype none

module sscd_cell (
    input  wire logic                  i_clk,
    input  wire sscd_pkg::t_cell_ctrl  i_ctrl,
    input  wire logic                  i_load_bit,
    input  wire logic                  i_shift_in,
    output logic                       o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        priority if (i_ctrl.load) begin
            n_bit = i_load_bit;
        end else if (i_ctrl.shift) begin
            n_bit = i_shift_in;
        end else begin
            n_bit = r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

`default_nettype wire

FILE: rtl/core/seven_segment_char_shift_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_char_shift_driver
// character to seven-segment frame encoder with a serial bit chain
// ----------------------------------------------------------------------------
// usage:
//   slave channel takes one character transaction: digit select, ascii code,
//   dot flag and display enable. master channel gives 16 transactions per
//   character, one per serial bit, first byte lsb first then second byte;
//   tlast marks the last bit, after which the external latch is pulsed.
// the character is loaded into the chain cells when it is taken; each bit then
//   passes through the output register. the 16-cell shift chain hands one bit
//   per cycle to the output register unless the receiver stalls it. the next
//   character is taken in the cycle the last bit leaves the chain, so a
//   continuous stream with no stall keeps the master channel busy every cycle.
// stall: when the receiver holds tready low the output register keeps its
//   bit and the chain stops; nothing is lost.
// reset: synchronous active-low; clears the busy flag, the bit count and the
//   output valid flag. the chain cells hold no reset and are loaded per
//   character.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_char_shift_driver_macros.svh"

module seven_segment_char_shift_driver (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [3:0] digit_select, [11:4] char_code, [12] dot_on, [13] display_on, [15:14] zero
    input  wire logic [sscd_pkg::InDataW-1:0]  i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [0] serial_bit, [4:1] bit_position, [7:5] zero
    output logic      [sscd_pkg::OutDataW-1:0] o_m_tdata,
    output logic                               o_m_tlast
);

    localparam int unsigned Cells = sscd_pkg::FrameBits;

    logic [Cells-1:0]          w_frame;
    logic [Cells-1:0]          w_bits;
    sscd_pkg::t_cell_ctrl      w_ctrl;
    logic                      w_move;
    logic                      w_take;

    logic                      r_busy;
    logic                      n_busy;
    logic [sscd_pkg::PosW-1:0] r_pos;
    logic [sscd_pkg::PosW-1:0] n_pos;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_out_bit;
    logic                      n_out_bit;
    logic [sscd_pkg::PosW-1:0] r_out_pos;
    logic [sscd_pkg::PosW-1:0] n_out_pos;
    logic                      r_out_last;
    logic                      n_out_last;

    sscd_encode u_encode (
        .i_digit_select (i_s_tdata[3:0]),
        .i_char_code    (i_s_tdata[11:4]),
        .i_dot_on       (i_s_tdata[12]),
        .i_display_on   (i_s_tdata[13]),
        .o_frame        (w_frame)
    );

    for (genvar k = 0; k < Cells; k++) begin : g_chain
        if (k == Cells - 1) begin : g_tail
            sscd_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_load_bit (w_frame[k]),
                .i_shift_in (1'b0),
                .o_bit      (w_bits[k])
            );
        end else begin : g_body
            sscd_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_load_bit (w_frame[k]),
                .i_shift_in (w_bits[k+1]),
                .o_bit      (w_bits[k])
            );
        end
    end

    // a bit leaves a busy chain whenever the output register is free or draining
    assign w_move      = r_busy && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_busy || (w_move && r_pos == sscd_pkg::LastPos);
    assign w_take      = i_s_tvalid && o_s_tready;
    assign w_ctrl.load  = w_take;
    assign w_ctrl.shift = w_move;

    always_comb begin
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_move) begin
            n_out_valid = 1'b1;
            n_out_bit   = w_bits[0];
            n_out_pos   = r_pos;
            n_out_last  = (r_pos == sscd_pkg::LastPos);
            n_pos       = r_pos + 1'b1;
            if (r_pos == sscd_pkg::LastPos) begin
                n_busy = 1'b0;
            end
        end

        if (w_take) begin
            n_busy = 1'b1;
            n_pos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bit  <= n_out_bit;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_pos, r_out_bit};
    assign o_m_tlast  = r_out_last;

    // a new character only enters an empty chain or as the last bit leaves
    `SSCD_ASSERT_NOW(a_take_when_free, i_clk, i_rst_n, w_take && r_busy,
                     w_move && r_pos == sscd_pkg::LastPos)
    // a taken character restarts the bit count
    `SSCD_ASSERT_NEXT(a_take_restarts, i_clk, i_rst_n, w_take, r_busy && r_pos == '0)
    // each moved bit advances the position by one
    `SSCD_ASSERT_NEXT(a_pos_advances, i_clk, i_rst_n, w_move && !w_take,
                      r_out_valid && r_out_pos == $past(r_pos)
                      && r_pos == $past(r_pos) + 1'b1)
    // tlast goes only with the final bit position
    `SSCD_ASSERT_NOW(a_last_at_end, i_clk, i_rst_n, r_out_valid,
                     r_out_last == (r_out_pos == sscd_pkg::LastPos))

endmodule

`default_nettype wire
